// File: src/wmvh_pkg.sv
// ----------------------------------------------------------------------------
// wmvh_pkg
// Shared types and constants for the windowed minimum voltage hold block.
// ----------------------------------------------------------------------------
package wmvh_pkg;

  localparam int unsigned MvW   = 16;
  localparam int unsigned ShowW = 15;
  localparam int unsigned TimeW = 64;
  localparam int unsigned IntvW = 32;

  localparam int unsigned InDataW  = MvW + TimeW;
  localparam int unsigned OutDataW = 16;

  localparam logic [IntvW-1:0] IntervalReset = 32'd1000000;

  typedef struct packed {
    logic                    ok;
    logic signed [MvW-1:0]   mv;
    logic signed [TimeW-1:0] t_us;
  } sample_t;

  typedef struct packed {
    logic             ok;
    logic [ShowW-1:0] mv;
  } shown_t;

endpackage

// File: src/wmvh_core.sv
// ----------------------------------------------------------------------------
// wmvh_core
// Window state and the one-pass update that runs for each sample beat.
// ----------------------------------------------------------------------------
module wmvh_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  wmvh_pkg::sample_t               sample,
  input  logic [wmvh_pkg::IntvW-1:0]      interval,
  output wmvh_pkg::shown_t                result
);

  logic                              have_shown_r, have_shown_nxt;
  logic                              win_has_r, win_has_nxt;
  logic [wmvh_pkg::TimeW-1:0]        win_start_r, win_start_nxt;
  logic [wmvh_pkg::ShowW-1:0]        win_low_r, win_low_nxt;
  logic [wmvh_pkg::ShowW-1:0]        shown_r, shown_nxt;

  logic                              valid;
  logic [wmvh_pkg::ShowW-1:0]        mv;
  logic [wmvh_pkg::TimeW:0]          diff;
  logic                              backwards;
  logic                              elapsed;
  logic                              take_low;
  logic [wmvh_pkg::ShowW-1:0]        low_upd;
  logic                              has_upd;

  assign valid = sample.ok && !sample.mv[wmvh_pkg::MvW-1];
  assign mv    = sample.mv[wmvh_pkg::ShowW-1:0];

  // signed compare and elapsed time from one 65-bit subtract
  assign diff      = {sample.t_us[wmvh_pkg::TimeW-1], sample.t_us}
                   - {win_start_r[wmvh_pkg::TimeW-1], win_start_r};
  assign backwards = diff[wmvh_pkg::TimeW];
  assign elapsed   = (|diff[wmvh_pkg::TimeW-1:wmvh_pkg::IntvW])
                   || (diff[wmvh_pkg::IntvW-1:0] >= interval);

  assign take_low = valid && (!win_has_r || (mv < win_low_r));
  assign low_upd  = take_low ? mv : win_low_r;
  assign has_upd  = win_has_r || take_low;

  always_comb begin
    have_shown_nxt = have_shown_r;
    win_has_nxt    = win_has_r;
    win_start_nxt  = win_start_r;
    win_low_nxt    = win_low_r;
    shown_nxt      = shown_r;
    if (!have_shown_r) begin
      if (valid) begin
        have_shown_nxt = 1'b1;
        win_has_nxt    = 1'b1;
        win_start_nxt  = sample.t_us;
        win_low_nxt    = mv;
        shown_nxt      = mv;
      end
    end else if (backwards) begin
      win_start_nxt = sample.t_us;
      win_has_nxt   = valid;
      if (valid) begin
        win_low_nxt = mv;
      end
    end else if (elapsed) begin
      if (has_upd) begin
        shown_nxt = low_upd;
      end
      win_start_nxt = sample.t_us;
      win_has_nxt   = valid;
      win_low_nxt   = valid ? mv : low_upd;
    end else begin
      win_has_nxt = has_upd;
      win_low_nxt = low_upd;
    end
  end

  always_comb begin
    result.ok = have_shown_nxt;
    result.mv = have_shown_nxt ? shown_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_shown_r <= 1'b0;
      win_has_r    <= 1'b0;
      win_start_r  <= '0;
      win_low_r    <= '0;
      shown_r      <= '0;
    end else if (step) begin
      have_shown_r <= have_shown_nxt;
      win_has_r    <= win_has_nxt;
      win_start_r  <= win_start_nxt;
      win_low_r    <= win_low_nxt;
      shown_r      <= shown_nxt;
    end
  end

endmodule

// File: src/windowed_minimum_voltage_hold.sv
// ----------------------------------------------------------------------------
// windowed_minimum_voltage_hold
// Holds the lowest valid battery voltage of each time window for display.
// ----------------------------------------------------------------------------
// Input beats carry one timestamped sample: tuser is the converter's ok flag,
// tdata the signed millivolt value and the signed microsecond timestamp.
// Each input beat yields exactly one output beat: tuser says whether a shown
// value exists yet, tdata carries the shown millivolts (zero until then).
// The cfg channel writes the window length in microseconds; cfg_ready is
// always high, and writes are expected only while the block is idle.
// An input beat passes through the input register, then the window update
// and the output register. Throughput is one beat per cycle while the output
// is not stalled; the 65-bit time subtract and compare are combinational.
// Reset (synchronous, rst_n low) clears both pipeline slots, the window
// state and loads the default interval of 1000000 us.
// When out_tready is low the output beat holds; the input register still
// takes a beat if it is empty, then in_tready drops until the output drains.
// ----------------------------------------------------------------------------
module windowed_minimum_voltage_hold (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wmvh_pkg::InDataW-1:0]      in_tdata,   // sample_mv, time_us
  input  logic                              in_tuser,   // sample_ok
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wmvh_pkg::OutDataW-1:0]     out_tdata,  // shown_mv, zero pad
  output logic                              out_tuser,  // shown_ok
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wmvh_pkg::IntvW-1:0]        cfg_data    // update_interval_us
);

  logic [wmvh_pkg::IntvW-1:0] interval_r;
  logic                       in_valid_r;
  wmvh_pkg::sample_t          in_r;
  logic                       out_valid_r;
  wmvh_pkg::shown_t           out_r;
  wmvh_pkg::shown_t           result;
  logic                       adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= wmvh_pkg::IntervalReset;
    end else if (cfg_valid) begin
      interval_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_r.ok   <= in_tuser;
      in_r.mv   <= in_tdata[wmvh_pkg::MvW-1:0];
      in_r.t_us <= in_tdata[wmvh_pkg::InDataW-1:wmvh_pkg::MvW];
    end
  end

  wmvh_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_valid_r && adv),
    .sample   (in_r),
    .interval (interval_r),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid_r) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.ok;
  assign out_tdata  = {{(wmvh_pkg::OutDataW - wmvh_pkg::ShowW){1'b0}}, out_r.mv};

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled while output slot could drain");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && adv) |=> out_valid_r)
    else $error("advanced beat did not reach output register");

  a_no_show_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.ok) |-> (out_r.mv == '0))
    else $error("shown value nonzero before first valid sample");

endmodule

// File: test/windowed_minimum_voltage_hold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_minimum_voltage_hold_tb
// Drives timestamped voltage samples through the stream ports and checks
// each returned beat against a scoreboard that tracks the window minimum,
// the shown value and the interval. Runs directed corner samples first,
// then random sample streams under several interval settings and idle mixes.
// ----------------------------------------------------------------------------
module windowed_minimum_voltage_hold_tb;
  import wmvh_pkg::*;

  class min_hold_scoreboard;
    logic [IntvW-1:0] interval;
    bit               have_shown;
    logic [TimeW-1:0] win_start;
    logic [MvW-1:0]   win_low;
    bit               win_full;
    logic [MvW-1:0]   shown_value;
    shown_t           predicted_shown[$];
    int unsigned      errors;

    function new();
      interval    = IntervalReset;
      have_shown  = 1'b0;
      win_start   = '0;
      win_low     = '0;
      win_full    = 1'b0;
      shown_value = '0;
      errors      = 0;
    endfunction

    function void note_sample(bit ok, logic [MvW-1:0] mv, logic [TimeW-1:0] t);
      bit valid;
      valid = ok && !mv[MvW-1];
      if (!have_shown) begin
        if (!valid) begin
          predicted_shown.push_back(shown_t'{ok: 1'b0, mv: '0});
          return;
        end
        win_start   = t;
        win_low     = mv;
        shown_value = mv;
        have_shown  = 1'b1;
        win_full    = 1'b1;
      end else if ($signed(t) < $signed(win_start)) begin
        // time went backwards: restart the window here
        win_start = t;
        win_full  = valid;
        if (valid) win_low = mv;
      end else begin
        if (valid && (!win_full || mv < win_low)) begin
          win_low  = mv;
          win_full = 1'b1;
        end
        if (t - win_start >= {32'd0, interval}) begin
          if (win_full) shown_value = win_low;
          win_start = t;
          win_full  = valid;
          if (valid) win_low = mv;
        end
      end
      predicted_shown.push_back(shown_t'{ok: 1'b1, mv: shown_value[ShowW-1:0]});
    endfunction

    function void check_result(bit ok, logic [OutDataW-1:0] data);
      shown_t exp;
      if (predicted_shown.size() == 0) begin
        $error("unexpected output beat: shown_ok=%0b shown_mv=%0d", ok, data);
        errors++;
        return;
      end
      exp = predicted_shown.pop_front();
      if (ok !== exp.ok) begin
        $error("shown_ok mismatch: expected %0b, actual %0b", exp.ok, ok);
        errors++;
      end
      if (data !== {1'b0, exp.mv}) begin
        $error("shown_mv mismatch: expected %0d, actual %0d", exp.mv, data);
        errors++;
      end
    endfunction

    function int pending();
      return predicted_shown.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;   // sample_mv, time_us
  logic                in_tuser;   // sample_ok
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;  // shown_mv, zero pad
  logic                out_tuser;  // shown_ok
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IntvW-1:0]    cfg_data;

  min_hold_scoreboard sb;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  logic [TimeW-1:0]   now_us;

  windowed_minimum_voltage_hold dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_sample(in_tuser, in_tdata[MvW-1:0], in_tdata[InDataW-1:MvW]);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tuser, out_tdata);
    end
  end

  task automatic send_sample(bit ok, logic [MvW-1:0] mv, logic [TimeW-1:0] t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ok;
    in_tdata  <= {t, mv};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    // let the monitor log the last accepted beat first
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(logic [IntvW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.interval = value;
  endtask

  task automatic random_samples(int count, logic [IntvW-1:0] interval);
    logic [TimeW-1:0] step_max;
    bit               ok;
    logic [MvW-1:0]   mv;
    int               r;
    step_max = {32'd0, interval} / 3 + 3;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 6) now_us = now_us - $urandom_range(1, step_max[31:0] + 1);
      else if (r < 9) now_us = {$urandom, $urandom};
      else if (r < 15) now_us = now_us;
      else if (r < 30) now_us = now_us + {32'd0, interval} + $urandom_range(0, 2);
      else now_us = now_us + $urandom_range(0, step_max[31:0]);

      r = $urandom_range(0, 99);
      if (r < 55) begin
        ok = 1'b1;
        mv = MvW'($urandom_range(3000, 4200));
      end else if (r < 70) begin
        ok = 1'b1;
        mv = MvW'($urandom_range(0, 32767));
      end else if (r < 85) begin
        ok = 1'b0;
        mv = MvW'($urandom);
      end else begin
        ok = 1'b1;
        mv = MvW'($urandom) | 16'h8000;
      end
      send_sample(ok, mv, now_us);
      if (i % 100 == 99) drain();
    end
  endtask

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [IntvW-1:0] intervals [6];
    sb = new();
    send_idle_pct = 14;
    recv_idle_pct = 45;
    now_us        = '0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing shown yet: invalid and negative samples report not ok
    send_sample(1'b0, 16'd100, 64'd0);
    send_sample(1'b1, 16'hFFFF, 64'd5);
    send_sample(1'b1, 16'h8000, 64'd6);
    send_sample(1'b0, 16'h7FFF, 64'd7);
    // first valid sample opens the window
    send_sample(1'b1, 16'd32767, 64'd0);
    send_sample(1'b1, 16'd5000, 64'd10);
    send_sample(1'b0, 16'd4000, 64'd20);
    send_sample(1'b1, 16'hFFFB, 64'd30);
    send_sample(1'b1, 16'd6000, 64'd1000000);
    // backwards in time, with and without a valid sample
    send_sample(1'b1, 16'd3000, 64'd500);
    send_sample(1'b0, 16'd3000, 64'd400);
    // window closes empty: shown value kept
    send_sample(1'b0, 16'd1, 64'd2000000);
    send_sample(1'b1, 16'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_sample(1'b1, 16'd32767, 64'h8000_0000_0000_0000);
    send_sample(1'b1, 16'd100, 64'h7FFF_FFFF_FFFF_FFFF);
    send_sample(1'b1, 16'd50, 64'hFFFF_FFFF_FFFF_FFFF);
    send_sample(1'b1, 16'd60, 64'h0000_0000_000F_4240);
    send_sample(1'b1, 16'd70, 64'h0000_0000_001E_847F);
    send_sample(1'b1, 16'd80, 64'h0000_0000_001E_8480);
    drain();

    intervals[0] = 32'd0;
    intervals[1] = 32'hFFFF_FFFF;
    intervals[2] = 32'd1000;
    intervals[3] = 32'd1;
    intervals[4] = 32'd250000;
    intervals[5] = IntvW'($urandom_range(2, 5000));
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 14;
        recv_idle_pct = 45;
      end else if (p < 4) begin
        send_idle_pct = 45;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_interval(intervals[p]);
      random_samples(267, intervals[p]);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
